// ===== hdl/pmtu_pkg.sv =====
`timescale 1ns / 1ps

package pmtu_pkg;

	// discovery phases
	typedef enum logic [2:0] {
		PH_DISABLED = 3'd0,
		PH_BASE     = 3'd1,
		PH_SEARCH   = 3'd2,
		PH_COMPLETE = 3'd3,
		PH_ERROR    = 3'd4
	} phase_t;

	// event codes
	localparam logic [2:0] REQ_START = 3'd0;
	localparam logic [2:0] REQ_ACK   = 3'd1;
	localparam logic [2:0] REQ_LOST  = 3'd2;
	localparam logic [2:0] REQ_RAISE = 3'd3;
	localparam logic [2:0] REQ_DLOSS = 3'd4;

	// probe delay choices
	localparam logic [1:0] DLY_NONE = 2'd0;
	localparam logic [1:0] DLY_ACK  = 2'd1;
	localparam logic [1:0] DLY_LOSS = 2'd2;

	// raise timer commands
	localparam logic [1:0] RT_KEEP     = 2'd0;
	localparam logic [1:0] RT_SCHEDULE = 2'd1;
	localparam logic [1:0] RT_CANCEL   = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_PROBE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_UNANS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BH_ENABLE = 3'd5;

	typedef struct packed {
		logic        discovery_enable;
		logic [15:0] base_size;
		logic [15:0] max_size;
		logic [15:0] error_probe_size;
		logic [7:0]  max_unanswered_probes;
		logic        blackhole_check_enable;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] acked_probe_size;
		logic        next_size_valid;
		logic [15:0] next_size;
		logic [7:0]  unanswered_probes;
		logic        lost_is_probe;
		logic [15:0] lost_size;
		logic        loss_threshold_hit;
	} item_t;

	typedef struct packed {
		phase_t      machine_state;
		logic [15:0] send_size;
		logic [15:0] probe_size;
		logic [1:0]  probe_delay;
		logic [1:0]  raise_timer_cmd;
		logic        stop_probe_timer;
		logic        send_probe_now;
		logic        upper_bound_found;
		logic        blackhole_found;
		logic        loss_counter_update;
		logic        size_raised;
		logic        event_ignored;
	} result_t;

endpackage

// ===== hdl/pmtu_probe_state_machine_core.sv =====
`timescale 1ns / 1ps

// Path MTU discovery probe controller. Each event item on the input channel
// yields exactly one result item, in order. An input register feeds the state
// update logic, which writes a result register. The result is loaded there when
// the result register is free, that is while it is empty or out_ready is high,
// and it is held there while out_ready is low. One event can be accepted every
// clock cycle while out_ready stays high. Sizes read zero until a start event.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only change while no event is in flight.
module pmtu_probe_state_machine_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pmtu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmtu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      req_type,
	input  logic [15:0]                     acked_probe_size,
	input  logic                            next_size_valid,
	input  logic [15:0]                     next_size,
	input  logic [7:0]                      unanswered_probes,
	input  logic                            lost_is_probe,
	input  logic [15:0]                     lost_size,
	input  logic                            loss_threshold_hit,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      machine_state,
	output logic [15:0]                     send_size,
	output logic [15:0]                     probe_size,
	output logic [1:0]                      probe_delay,
	output logic [1:0]                      raise_timer_cmd,
	output logic                            stop_probe_timer,
	output logic                            send_probe_now,
	output logic                            upper_bound_found,
	output logic                            blackhole_found,
	output logic                            loss_counter_update,
	output logic                            size_raised,
	output logic                            event_ignored
);
	import pmtu_pkg::*;

	cfg_t    cfg;
	item_t   item;
	result_t res_d, res_q;
	logic    adv, out_free;

	assign item.req_type           = req_type;
	assign item.acked_probe_size   = acked_probe_size;
	assign item.next_size_valid    = next_size_valid;
	assign item.next_size          = next_size;
	assign item.unanswered_probes  = unanswered_probes;
	assign item.lost_is_probe      = lost_is_probe;
	assign item.lost_size          = lost_size;
	assign item.loss_threshold_hit = loss_threshold_hit;

	pmtu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pmtu_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.out_free (out_free),
		.adv      (adv),
		.res_d    (res_d)
	);

	pmtu_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res_d     (res_d),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// result fields
	assign machine_state       = res_q.machine_state;
	assign send_size           = res_q.send_size;
	assign probe_size          = res_q.probe_size;
	assign probe_delay         = res_q.probe_delay;
	assign raise_timer_cmd     = res_q.raise_timer_cmd;
	assign stop_probe_timer    = res_q.stop_probe_timer;
	assign send_probe_now      = res_q.send_probe_now;
	assign upper_bound_found   = res_q.upper_bound_found;
	assign blackhole_found     = res_q.blackhole_found;
	assign loss_counter_update = res_q.loss_counter_update;
	assign size_raised         = res_q.size_raised;
	assign event_ignored       = res_q.event_ignored;

endmodule

// ===== hdl/pmtu_cfg.sv =====
`timescale 1ns / 1ps

module pmtu_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pmtu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pmtu_pkg::CFG_DATA_W-1:0]      cfg_data,
	output pmtu_pkg::cfg_t                       cfg
);
	import pmtu_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.discovery_enable       <= 1'b1;
			cfg_q.base_size              <= 16'd1252;
			cfg_q.max_size               <= 16'd1452;
			cfg_q.error_probe_size       <= 16'd1200;
			cfg_q.max_unanswered_probes  <= 8'd3;
			cfg_q.blackhole_check_enable <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:    cfg_q.discovery_enable       <= cfg_data[0];
				CFG_BASE:      cfg_q.base_size              <= cfg_data[15:0];
				CFG_MAX:       cfg_q.max_size               <= cfg_data[15:0];
				CFG_ERR_PROBE: cfg_q.error_probe_size       <= cfg_data[15:0];
				CFG_MAX_UNANS: cfg_q.max_unanswered_probes  <= cfg_data[7:0];
				CFG_BH_ENABLE: cfg_q.blackhole_check_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/pmtu_fsm.sv =====
`timescale 1ns / 1ps

module pmtu_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  pmtu_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  pmtu_pkg::item_t   item,
	input  logic              out_free,
	output logic              adv,
	output pmtu_pkg::result_t res_d
);
	import pmtu_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	phase_t      phase_q, phase_d;
	logic [15:0] send_q, send_d;
	logic [15:0] probe_q, probe_d;

	logic stale, nok_cur, nok_raised, limit, loss_qual;

	// input stage
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item;
		end
	end

	// shared compares
	assign stale      = item_s1.acked_probe_size <= send_q;
	assign nok_cur    = item_s1.next_size_valid && (item_s1.next_size > send_q)
		&& (item_s1.next_size <= cfg.max_size);
	assign nok_raised = item_s1.next_size_valid
		&& (item_s1.next_size > item_s1.acked_probe_size)
		&& (item_s1.next_size <= cfg.max_size);
	assign limit      = item_s1.unanswered_probes >= cfg.max_unanswered_probes;
	assign loss_qual  = (phase_q != PH_DISABLED) && !item_s1.lost_is_probe
		&& (item_s1.lost_size > cfg.base_size) && (send_q > cfg.base_size)
		&& cfg.blackhole_check_enable;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (item_s1.req_type)
			REQ_START: begin
				phase_d = cfg.discovery_enable ? PH_BASE : PH_DISABLED;
			end
			REQ_ACK: begin
				unique case (phase_q)
					PH_BASE: begin
						if (item_s1.acked_probe_size != cfg.base_size) begin
							phase_d = (stale || nok_raised) ? PH_SEARCH : PH_COMPLETE;
						end else begin
							phase_d = nok_cur ? PH_SEARCH : PH_COMPLETE;
						end
					end
					PH_SEARCH: begin
						if (!stale && !nok_raised) begin
							phase_d = PH_COMPLETE;
						end
					end
					PH_ERROR: phase_d = PH_BASE;
					default:  phase_d = phase_q;
				endcase
			end
			REQ_LOST: begin
				if (phase_q == PH_BASE && limit) begin
					phase_d = PH_ERROR;
				end else if (phase_q == PH_SEARCH && limit) begin
					phase_d = PH_COMPLETE;
				end
			end
			REQ_RAISE: begin
				if (phase_q == PH_COMPLETE) begin
					phase_d = PH_SEARCH;
				end
			end
			REQ_DLOSS: begin
				if (loss_qual && item_s1.loss_threshold_hit) begin
					phase_d = PH_BASE;
				end
			end
			default: phase_d = phase_q;
		endcase
	end

	// sizes and event flags
	always_comb begin
		send_d = send_q;
		probe_d = probe_q;
		res_d = '0;
		unique case (item_s1.req_type)
			REQ_START: begin
				send_d  = cfg.base_size;
				probe_d = cfg.base_size;
			end
			REQ_ACK: begin
				if (phase_q == PH_SEARCH
					|| (phase_q == PH_BASE
					&& item_s1.acked_probe_size != cfg.base_size)) begin
					if (stale) begin
						res_d.event_ignored = 1'b1;
					end else begin
						send_d = item_s1.acked_probe_size;
						res_d.size_raised = 1'b1;
						if (nok_raised) begin
							probe_d = item_s1.next_size;
							res_d.probe_delay = DLY_ACK;
						end else begin
							res_d.raise_timer_cmd   = RT_SCHEDULE;
							res_d.stop_probe_timer  = 1'b1;
							res_d.upper_bound_found = 1'b1;
						end
					end
				end else if (phase_q == PH_BASE) begin
					if (nok_cur) begin
						probe_d = item_s1.next_size;
						res_d.probe_delay = DLY_ACK;
					end else begin
						res_d.raise_timer_cmd   = RT_SCHEDULE;
						res_d.stop_probe_timer  = 1'b1;
						res_d.upper_bound_found = 1'b1;
					end
				end else if (phase_q == PH_ERROR) begin
					probe_d = cfg.base_size;
					res_d.probe_delay = DLY_ACK;
				end else begin
					res_d.event_ignored = 1'b1;
				end
			end
			REQ_LOST: begin
				if (phase_q == PH_BASE) begin
					if (limit) begin
						probe_d = cfg.error_probe_size;
					end
					res_d.probe_delay = DLY_LOSS;
				end else if (phase_q == PH_SEARCH) begin
					if (limit) begin
						res_d.raise_timer_cmd   = RT_SCHEDULE;
						res_d.stop_probe_timer  = 1'b1;
						res_d.upper_bound_found = 1'b1;
					end else begin
						res_d.probe_delay = DLY_LOSS;
					end
				end else if (phase_q == PH_ERROR) begin
					res_d.probe_delay = DLY_LOSS;
				end else begin
					res_d.event_ignored = 1'b1;
				end
			end
			REQ_RAISE: begin
				if (phase_q == PH_COMPLETE) begin
					res_d.send_probe_now = 1'b1;
				end else begin
					res_d.event_ignored = 1'b1;
				end
			end
			REQ_DLOSS: begin
				if (loss_qual) begin
					res_d.loss_counter_update = 1'b1;
					if (item_s1.loss_threshold_hit) begin
						res_d.blackhole_found = 1'b1;
						res_d.raise_timer_cmd = RT_CANCEL;
						send_d  = cfg.base_size;
						probe_d = cfg.base_size;
					end
				end
			end
			default: res_d.event_ignored = 1'b1;
		endcase
		res_d.machine_state = phase_d;
		res_d.send_size     = send_d;
		res_d.probe_size    = probe_d;
	end

	// machine state, updated once per transfer into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DISABLED;
			send_q  <= '0;
			probe_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			send_q  <= send_d;
			probe_q <= probe_d;
		end
	end

	// state only moves when an item leaves the input stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q) && $stable(send_q) && $stable(probe_q))
		else $error("state changed without a transfer");

	// a raise always lands on the acked probe size
	a_raise: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_d.size_raised |=> send_q == $past(item_s1.acked_probe_size))
		else $error("raised send size differs from acked size");

	// black hole drops both sizes to base and returns to base phase
	a_bh: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_d.blackhole_found |=> phase_q == PH_BASE && send_q == probe_q)
		else $error("black hole did not reset sizes");

	// upper bound event only with the search complete
	a_ub: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_d.upper_bound_found |=> phase_q == PH_COMPLETE)
		else $error("upper bound outside complete phase");

endmodule

// ===== hdl/pmtu_out.sv =====
`timescale 1ns / 1ps

module pmtu_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pmtu_pkg::result_t res_d,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output pmtu_pkg::result_t res_q
);
	import pmtu_pkg::*;

	logic valid_s2;
	result_t res_s2;

	// result stage can take a new item when empty or being drained
	assign free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid = valid_s2;
	assign res_q     = res_s2;

endmodule
